/* sv/trvp_pkg.sv */
package trvp_pkg;

  // record layout and varint limits
  localparam int MinutesPerDay = 24 * 60;
  localparam int MagW          = 62;
  localparam int FirstShift    = 6;
  localparam int ShiftStep     = 7;
  localparam int MaxShift      = 55;
  localparam int FieldCount    = 4;

  // default depth of the result queue
  localparam int ResultDepth   = 4;

  // register indexes on the configuration port
  localparam logic RegRecordCount = 1'b0;
  localparam logic RegStartIndex  = 1'b1;

  // position inside a record
  typedef enum logic [2:0] {
    PhTimeLo = 3'd0,
    PhTimeHi = 3'd1,
    PhPrice  = 3'd2,
    PhVolume = 3'd3,
    PhOrders = 3'd4,
    PhStatus = 3'd5,
    PhTail   = 3'd6
  } phase_e;

  // result status codes
  typedef enum logic [3:0] {
    ErrNone      = 4'd0,
    ErrNoTime    = 4'd1,
    ErrMissing   = 4'd2,
    ErrNoTerm    = 4'd3,
    ErrTooLong   = 4'd4,
    ErrBadMinute = 4'd5,
    ErrNegCount  = 4'd6,
    ErrOverflow  = 4'd7,
    ErrNegPrice  = 4'd8
  } err_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       payload_end;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        record_number;
    logic [16:0]        absolute_number;
    logic [10:0]        minute_of_day;
    logic signed [63:0] price_step;
    logic signed [63:0] price_running;
    logic [62:0]        volume;
    logic [62:0]        orders;
    logic signed [63:0] status_word;
    logic signed [63:0] tail_word;
    logic [3:0]         error_code;
    logic               last_of_run;
  } out_item_t;

  // write strobes into the result queue; two implies one
  typedef struct packed {
    logic one;
    logic two;
  } push_t;

endpackage

/* sv/trvp_result_fifo.sv */
module trvp_result_fifo #(
  parameter int Depth = trvp_pkg::ResultDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  trvp_pkg::push_t     push_i,
  input  trvp_pkg::out_item_t entry0_i,
  input  trvp_pkg::out_item_t entry1_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output trvp_pkg::out_item_t out_data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  trvp_pkg::out_item_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, wptr_nx, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [1:0]      n_push;
  logic            pop;

  assign wptr_nx     = ptr_inc(wptr_q);
  assign pop         = out_valid_o && !out_stall_i;
  assign n_push      = 2'(push_i.one) + 2'(push_i.two);
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rptr_q];
  // room for the two results one byte may cause
  assign room_o      = (cnt_q <= CntW'(Depth - 2));

  // pointer and fill count
  always_comb begin
    wptr_d = wptr_q;
    if (push_i.two) begin
      wptr_d = ptr_inc(wptr_nx);
    end else if (push_i.one) begin
      wptr_d = wptr_nx;
    end
    rptr_d = pop ? ptr_inc(rptr_q) : rptr_q;
    cnt_d  = cnt_q + CntW'(n_push) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // result storage
  always_ff @(posedge clk_i) begin
    if (push_i.one) begin
      mem_q[wptr_q] <= entry0_i;
    end
    if (push_i.two) begin
      mem_q[wptr_nx] <= entry1_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("result queue over full");

  a_two_needs_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.two |-> push_i.one)
    else $error("second result without first");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.one |-> (cnt_q <= CntW'(Depth - 2)))
    else $error("result written without room");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push_i.one) |=> (cnt_q == $past(cnt_q) - CntW'(1)))
    else $error("fill count lost a transfer");

endmodule

/* sv/trade_record_varint_parser.sv */
// channel   direction  handshake                        payload
// in        input      in_valid_i / in_stall_o          in_data_i  (data_byte, payload_end)
// out       output     out_valid_o / out_stall_i        out_data_o (record or error result)
// cfg       input      psel, penable, pwrite, pready    paddr, pwdata, prdata
//
// one byte is taken per cycle while the queue has room; its results enter the queue
// at the same edge; from an empty queue the first one is offered in the next cycle
// a byte causes zero, one or two results; the result queue drains one per cycle,
// so two-result bytes and a stalled output stop input once fewer than two slots are free
// rst_ni clears control state at once; no clearing pass is needed
// field registers of a record are written before they are read and are not reset
module trade_record_varint_parser #(
  parameter int ResultDepth = trvp_pkg::ResultDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  trvp_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output trvp_pkg::out_item_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int MagW = trvp_pkg::MagW;

  // configuration registers
  logic [15:0] record_count_q, start_index_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      record_count_q <= '0;
      start_index_q  <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        trvp_pkg::RegRecordCount: record_count_q <= pwdata[15:0];
        trvp_pkg::RegStartIndex:  start_index_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[2])
      trvp_pkg::RegRecordCount: prdata = {16'b0, record_count_q};
      trvp_pkg::RegStartIndex:  prdata = {16'b0, start_index_q};
      default:                  prdata = '0;
    endcase
  end

  // parser state
  trvp_pkg::phase_e   phase_q, phase_d;
  logic [7:0]         tlow_q, tlow_d;
  logic [10:0]        minute_q, minute_d;
  logic [MagW-1:0]    mag_q, mag_d;
  logic [5:0]         shift_q, shift_d;
  logic               sign_q, sign_d;
  logic               in_var_q, in_var_d;
  logic signed [63:0] price_q, price_d;
  logic [15:0]        cnt_q, cnt_d;
  logic               halted_q, halted_d;
  logic signed [63:0] field_q [trvp_pkg::FieldCount];

  logic                accept, room, active, byte_end;
  logic [7:0]          b;
  logic [15:0]         t_word;
  logic [MagW-1:0]     grp, mag_nx;
  logic                sign_nx, cont_nx;
  logic [63:0]         mag64;
  logic signed [63:0]  val;
  logic [64:0]         sum;
  logic                field_wr, rec_done;
  logic [1:0]          field_idx;
  logic [15:0]         cnt_inc;
  trvp_pkg::err_e      err;
  trvp_pkg::push_t     push;
  trvp_pkg::out_item_t rec_res, err_res, entry0, entry1;

  assign in_stall_o = !room;
  assign accept     = in_valid_i && room;
  assign b          = in_data_i.data_byte;
  assign byte_end   = in_data_i.payload_end;
  assign active     = !halted_q && (cnt_q < record_count_q);
  assign t_word     = {b, tlow_q};
  assign grp        = MagW'(b[6:0]) << shift_q;
  assign field_idx  = 2'(phase_q - trvp_pkg::PhPrice);
  assign cnt_inc    = cnt_q + 16'd1;
  // running price plus the stored step, one bit wider to see overflow
  assign sum        = {price_q[63], price_q} + {field_q[0][63], field_q[0]};

  // per-byte decode
  always_comb begin
    phase_d  = phase_q;
    tlow_d   = tlow_q;
    minute_d = minute_q;
    mag_d    = mag_q;
    shift_d  = shift_q;
    sign_d   = sign_q;
    in_var_d = in_var_q;
    price_d  = price_q;
    cnt_d    = cnt_q;
    halted_d = halted_q;
    err      = trvp_pkg::ErrNone;
    field_wr = 1'b0;
    rec_done = 1'b0;
    mag_nx   = mag_q;
    sign_nx  = sign_q;
    cont_nx  = in_var_q;
    mag64    = '0;
    val      = '0;

    if (accept && active) begin
      unique case (phase_q) inside
        trvp_pkg::PhTimeLo: begin
          tlow_d  = b;
          phase_d = trvp_pkg::PhTimeHi;
          if (byte_end) err = trvp_pkg::ErrNoTime;
        end
        trvp_pkg::PhTimeHi: begin
          if (t_word >= 16'(trvp_pkg::MinutesPerDay)) begin
            err = trvp_pkg::ErrBadMinute;
          end else begin
            minute_d = t_word[10:0];
            phase_d  = trvp_pkg::PhPrice;
            in_var_d = 1'b0;
            if (byte_end) err = trvp_pkg::ErrMissing;
          end
        end
        trvp_pkg::PhPrice, trvp_pkg::PhVolume, trvp_pkg::PhOrders,
        trvp_pkg::PhStatus, trvp_pkg::PhTail: begin
          // accumulate the varint; groups never overlap so or-ing adds
          if (!in_var_q) begin
            mag_nx  = MagW'(b[5:0]);
            sign_nx = b[6];
            cont_nx = b[7];
            shift_d = 6'(trvp_pkg::FirstShift);
          end else if (shift_q > 6'(trvp_pkg::MaxShift)) begin
            err = trvp_pkg::ErrTooLong;
          end else begin
            mag_nx  = mag_q | grp;
            cont_nx = b[7];
            shift_d = shift_q + 6'(trvp_pkg::ShiftStep);
          end
          mag_d    = mag_nx;
          sign_d   = sign_nx;
          in_var_d = cont_nx;
          mag64    = {2'b00, mag_nx};
          val      = sign_nx ? -$signed(mag64) : $signed(mag64);

          if (err == trvp_pkg::ErrNone) begin
            if (cont_nx) begin
              if (byte_end) err = trvp_pkg::ErrNoTerm;
            end else if (phase_q != trvp_pkg::PhTail) begin
              field_wr = 1'b1;
              phase_d  = trvp_pkg::phase_e'(phase_q + 3'd1);
              if (byte_end) err = trvp_pkg::ErrMissing;
            end else if (field_q[1][63] || field_q[2][63]) begin
              err = trvp_pkg::ErrNegCount;
            end else if (sum[64] != sum[63]) begin
              err = trvp_pkg::ErrOverflow;
            end else if (sum[63]) begin
              err = trvp_pkg::ErrNegPrice;
            end else begin
              // record complete
              price_d  = sum[63:0];
              rec_done = 1'b1;
              cnt_d    = cnt_inc;
              phase_d  = trvp_pkg::PhTimeLo;
              if (byte_end && (cnt_inc < record_count_q)) err = trvp_pkg::ErrNoTime;
            end
          end
        end
        default: ;
      endcase
      if (err != trvp_pkg::ErrNone) halted_d = 1'b1;
    end

    // payload end re-arms the parser
    if (accept && byte_end) begin
      phase_d  = trvp_pkg::PhTimeLo;
      in_var_d = 1'b0;
      shift_d  = '0;
      sign_d   = 1'b0;
      mag_d    = '0;
      price_d  = '0;
      cnt_d    = '0;
      halted_d = 1'b0;
    end
  end

  // result items for this byte
  always_comb begin
    rec_res.record_number   = cnt_q;
    rec_res.absolute_number = 17'(start_index_q) + 17'(cnt_q);
    rec_res.minute_of_day   = minute_q;
    rec_res.price_step      = field_q[0];
    rec_res.price_running   = sum[63:0];
    rec_res.volume          = field_q[1][62:0];
    rec_res.orders          = field_q[2][62:0];
    rec_res.status_word     = field_q[3];
    rec_res.tail_word       = val;
    rec_res.error_code      = trvp_pkg::ErrNone;
    rec_res.last_of_run     = (err == trvp_pkg::ErrNone);

    err_res                 = '0;
    err_res.record_number   = rec_done ? cnt_inc : cnt_q;
    err_res.absolute_number = 17'(start_index_q) + 17'(err_res.record_number);
    err_res.error_code      = err;
    err_res.last_of_run     = 1'b1;

    push.one = rec_done || (err != trvp_pkg::ErrNone);
    push.two = rec_done && (err != trvp_pkg::ErrNone);
    entry0   = rec_done ? rec_res : err_res;
    entry1   = err_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= trvp_pkg::PhTimeLo;
      tlow_q   <= '0;
      minute_q <= '0;
      mag_q    <= '0;
      shift_q  <= '0;
      sign_q   <= 1'b0;
      in_var_q <= 1'b0;
      price_q  <= '0;
      cnt_q    <= '0;
      halted_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      tlow_q   <= tlow_d;
      minute_q <= minute_d;
      mag_q    <= mag_d;
      shift_q  <= shift_d;
      sign_q   <= sign_d;
      in_var_q <= in_var_d;
      price_q  <= price_d;
      cnt_q    <= cnt_d;
      halted_q <= halted_d;
    end
  end

  // record field store
  always_ff @(posedge clk_i) begin
    if (field_wr) begin
      field_q[field_idx] <= val;
    end
  end

  trvp_result_fifo #(
    .Depth(ResultDepth)
  ) u_result_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .entry0_i   (entry0),
    .entry1_i   (entry1),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

/* test/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QuietLimit = 2000;
  localparam int SettleCycles = 4;
  localparam int PhaseCnt = 10;
  localparam int BytesPerPhase = 160;

  // one row of the directed table; typed rows carry their own expected error
  typedef struct packed {
    logic [7:0]     data;
    logic           fin;
    logic [3:0]     reps;
    logic           typed;
    trvp_pkg::err_e err;
  } dir_row_t;

  localparam int DirLen = 27;
  localparam dir_row_t DirRows [DirLen] = '{
    // payload ends after the first time byte
    '{8'h00, 1'b1, 4'd1, 1'b1, trvp_pkg::ErrNoTime},
    // minute 1440 is out of range
    '{8'hA0, 1'b0, 4'd1, 1'b1, trvp_pkg::ErrNone},
    '{8'h05, 1'b1, 4'd1, 1'b1, trvp_pkg::ErrBadMinute},
    // minute 1439, largest price step, negative zero volume, two-byte zero orders,
    // record completes on the last byte and the second record is missing
    '{8'h9F, 1'b0, 4'd1, 1'b0, trvp_pkg::ErrNone},
    '{8'h05, 1'b0, 4'd1, 1'b0, trvp_pkg::ErrNone},
    '{8'hBF, 1'b0, 4'd1, 1'b0, trvp_pkg::ErrNone},
    '{8'hFF, 1'b0, 4'd7, 1'b0, trvp_pkg::ErrNone},
    '{8'h7F, 1'b0, 4'd1, 1'b0, trvp_pkg::ErrNone},
    '{8'h40, 1'b0, 4'd1, 1'b0, trvp_pkg::ErrNone},
    '{8'h80, 1'b0, 4'd1, 1'b0, trvp_pkg::ErrNone},
    '{8'h00, 1'b0, 4'd1, 1'b0, trvp_pkg::ErrNone},
    '{8'h7F, 1'b0, 4'd1, 1'b0, trvp_pkg::ErrNone},
    '{8'h3F, 1'b1, 4'd1, 1'b0, trvp_pkg::ErrNone},
    // varint one byte too long, then ignored bytes up to the end
    '{8'h00, 1'b0, 4'd2, 1'b1, trvp_pkg::ErrNone},
    '{8'h80, 1'b0, 4'd1, 1'b1, trvp_pkg::ErrNone},
    '{8'hFF, 1'b0, 4'd8, 1'b1, trvp_pkg::ErrNone},
    '{8'h00, 1'b0, 4'd1, 1'b1, trvp_pkg::ErrTooLong},
    '{8'h55, 1'b0, 4'd3, 1'b1, trvp_pkg::ErrNone},
    '{8'h00, 1'b1, 4'd1, 1'b1, trvp_pkg::ErrNone},
    // payload ends inside a varint
    '{8'h00, 1'b0, 4'd2, 1'b1, trvp_pkg::ErrNone},
    '{8'h80, 1'b1, 4'd1, 1'b1, trvp_pkg::ErrNoTerm},
    // payload ends right after the time
    '{8'h00, 1'b0, 4'd1, 1'b1, trvp_pkg::ErrNone},
    '{8'h00, 1'b1, 4'd1, 1'b1, trvp_pkg::ErrMissing},
    // first price step of -1 drives the running price below zero
    '{8'h00, 1'b0, 4'd2, 1'b1, trvp_pkg::ErrNone},
    '{8'h41, 1'b0, 4'd1, 1'b1, trvp_pkg::ErrNone},
    '{8'h00, 1'b0, 4'd3, 1'b1, trvp_pkg::ErrNone},
    '{8'h00, 1'b1, 4'd1, 1'b1, trvp_pkg::ErrNegPrice}
  };

  // register settings of the random phases
  localparam logic [15:0] PhaseRecords [PhaseCnt] = '{
    16'd1, 16'd3, 16'd0, 16'd5, 16'd2, 16'hFFFF, 16'd4, 16'd1, 16'd6, 16'd2
  };
  localparam logic [15:0] PhaseStarts [PhaseCnt] = '{
    16'd0, 16'h1234, 16'd12, 16'hFFFF, 16'd40000, 16'd7, 16'hA5C3, 16'hFFFF, 16'd300, 16'd1
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  trvp_pkg::in_item_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  trvp_pkg::out_item_t out_data_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  trade_record_varint_parser dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #6 clk_i = ~clk_i;

  // decoder mirror: registers and record state
  logic [15:0]        cfg_records;
  logic [15:0]        cfg_start;
  trvp_pkg::phase_e   ph;
  logic [7:0]         lo_byte;
  logic [10:0]        minute_q;
  logic [61:0]        mag_acc;
  logic [5:0]         shift_q;
  logic               sign_q;
  logic               cont_q;
  logic signed [63:0] fld [trvp_pkg::FieldCount];
  logic signed [63:0] price_sum;
  logic [15:0]        rec_cnt;
  logic               stopped;

  trvp_pkg::out_item_t byte_res [2];
  int                  byte_res_n;
  trvp_pkg::out_item_t pending_results [$];

  int send_pct;
  int recv_pct;
  int quiet_cycles = 0;
  int mismatches = 0;
  int bytes_sent = 0;
  int live_bytes = 0;
  int records_seen = 0;
  int errors_seen = 0;
  logic [15:0] codes_seen = '0;

  // stimulus scratch
  logic [7:0]         pay_q [$];
  logic signed [63:0] gen_price;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic clear_record_state();
    ph = trvp_pkg::PhTimeLo;
    cont_q = 1'b0;
    shift_q = '0;
    sign_q = 1'b0;
    mag_acc = '0;
    price_sum = '0;
    rec_cnt = '0;
    stopped = 1'b0;
  endtask

  task automatic emit(input logic [10:0] minute, input logic signed [63:0] stp,
                      input logic signed [63:0] run, input logic signed [63:0] vol,
                      input logic signed [63:0] ord, input logic signed [63:0] st,
                      input logic signed [63:0] tl, input trvp_pkg::err_e err);
    trvp_pkg::out_item_t r;
    r.record_number = rec_cnt;
    r.absolute_number = 17'(cfg_start) + 17'(rec_cnt);
    r.minute_of_day = minute;
    r.price_step = stp;
    r.price_running = run;
    r.volume = vol[62:0];
    r.orders = ord[62:0];
    r.status_word = st;
    r.tail_word = tl;
    r.error_code = err;
    r.last_of_run = 1'b0;
    byte_res[byte_res_n] = r;
    byte_res_n++;
  endtask

  // advance the mirror by one byte and collect the results it causes
  task automatic decode_byte(input trvp_pkg::in_item_t it);
    logic [7:0]         b;
    logic               fin;
    trvp_pkg::err_e     err;
    logic [15:0]        t;
    logic signed [63:0] magv;
    logic signed [63:0] v;
    logic signed [63:0] stp;
    logic signed [63:0] run;
    b = it.data_byte;
    fin = it.payload_end;
    err = trvp_pkg::ErrNone;
    byte_res_n = 0;
    if (!stopped && rec_cnt < cfg_records) begin
      live_bytes++;
      if (ph == trvp_pkg::PhTimeLo) begin
        lo_byte = b;
        ph = trvp_pkg::PhTimeHi;
        if (fin) err = trvp_pkg::ErrNoTime;
      end else if (ph == trvp_pkg::PhTimeHi) begin
        t = {b, lo_byte};
        if (t >= trvp_pkg::MinutesPerDay) begin
          err = trvp_pkg::ErrBadMinute;
        end else begin
          minute_q = t[10:0];
          ph = trvp_pkg::PhPrice;
          cont_q = 1'b0;
          if (fin) err = trvp_pkg::ErrMissing;
        end
      end else begin
        // varint byte: first byte has sign and six bits, later bytes seven bits
        if (!cont_q) begin
          mag_acc = {56'b0, b[5:0]};
          shift_q = 6'(trvp_pkg::FirstShift);
          sign_q = b[6];
          cont_q = b[7];
        end else if (shift_q > trvp_pkg::MaxShift) begin
          err = trvp_pkg::ErrTooLong;
        end else begin
          mag_acc = mag_acc + (62'(b[6:0]) << shift_q);
          shift_q = shift_q + 6'(trvp_pkg::ShiftStep);
          cont_q = b[7];
        end
        if (err == trvp_pkg::ErrNone && cont_q) begin
          if (fin) err = trvp_pkg::ErrNoTerm;
        end else if (err == trvp_pkg::ErrNone) begin
          magv = {2'b00, mag_acc};
          v = sign_q ? -magv : magv;
          if (ph != trvp_pkg::PhTail) begin
            fld[ph - trvp_pkg::PhPrice] = v;
            ph = trvp_pkg::phase_e'(ph + 3'd1);
            if (fin) err = trvp_pkg::ErrMissing;
          end else begin
            // record complete: check counts and the running price
            stp = fld[0];
            run = price_sum + stp;
            if (fld[1] < 0 || fld[2] < 0) begin
              err = trvp_pkg::ErrNegCount;
            end else if (price_sum[63] == stp[63] && run[63] != stp[63]) begin
              err = trvp_pkg::ErrOverflow;
            end else if (run < 0) begin
              err = trvp_pkg::ErrNegPrice;
            end else begin
              price_sum = run;
              emit(minute_q, stp, run, fld[1], fld[2], fld[3], v, trvp_pkg::ErrNone);
              rec_cnt++;
              ph = trvp_pkg::PhTimeLo;
              if (fin && rec_cnt < cfg_records) err = trvp_pkg::ErrNoTime;
            end
          end
        end
      end
      if (err != trvp_pkg::ErrNone) begin
        stopped = 1'b1;
        emit('0, '0, '0, '0, '0, '0, '0, err);
      end
    end
    if (byte_res_n > 0) byte_res[byte_res_n - 1].last_of_run = 1'b1;
    if (fin) clear_record_state();
  endtask

  // present one byte after idle cycles drawn cycle by cycle, wait for its transfer
  task automatic send_item(input trvp_pkg::in_item_t it);
    while ($urandom_range(99) < send_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
  endtask

  // send a byte and queue what it should produce
  task automatic feed(input trvp_pkg::in_item_t it, input logic typed,
                      input trvp_pkg::err_e terr);
    trvp_pkg::out_item_t e;
    send_item(it);
    if (typed) begin
      e = '0;
      e.absolute_number = 17'(cfg_start) + 17'(rec_cnt);
      e.error_code = terr;
      e.last_of_run = 1'b1;
    end
    decode_byte(it);
    if (typed) begin
      if (terr != trvp_pkg::ErrNone) pending_results.insert(pending_results.size(), e);
    end else begin
      for (int i = 0; i < byte_res_n; i++)
        pending_results.insert(pending_results.size(), byte_res[i]);
    end
  endtask

  // hold the input idle until every expected result has been taken
  task automatic quiesce();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // register write followed by a read back
  task automatic write_reg(input logic idx, input logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'b0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == trvp_pkg::RegRecordCount) cfg_records = value;
    else cfg_start = value;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {16'b0, value})
      report_mismatch($sformatf("register %0d read %h, wrote %h", idx, prdata, value));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_idle(input int mode);
    case (mode)
      0: begin
        send_pct = 27;
        recv_pct = 53;
      end
      1: begin
        send_pct = 53;
        recv_pct = 27;
      end
      default: begin
        send_pct = 0;
        recv_pct = 0;
      end
    endcase
  endtask

  // random magnitude spanning a random number of varint bytes
  function automatic logic [61:0] rand_mag();
    logic [63:0] r64;
    int r;
    int n;
    r64 = {$urandom, $urandom};
    r = $urandom_range(99);
    if (r < 50) n = 1;
    else if (r < 80) n = $urandom_range(2, 3);
    else if (r < 95) n = $urandom_range(4, 8);
    else n = 9;
    return r64[61:0] >> (62 - (6 + 7 * (n - 1)));
  endfunction

  // encode a varint, sometimes with an extra zero group or one byte too many
  task automatic put_varint(input logic neg, input logic [61:0] mag);
    int n;
    int r;
    int sh;
    logic [63:0] m64;
    m64 = {2'b00, mag};
    n = 1;
    while (n < 9 && (m64 >> (6 + 7 * (n - 1))) != 0) n++;
    r = $urandom_range(99);
    if (r < 2) n = 10;
    else if (r < 10 && n < 9) n++;
    pay_q.insert(pay_q.size(), {1'b1 && (n > 1), neg, mag[5:0]});
    for (int i = 1; i < n; i++) begin
      sh = 6 + 7 * (i - 1);
      if (sh < 62)
        pay_q.insert(pay_q.size(), {1'b1 && (i < n - 1), 7'((m64 >> sh) & 64'h7F)});
      else pay_q.insert(pay_q.size(), {1'b1 && (i < n - 1), 7'($urandom)});
    end
  endtask

  // count field: mostly non-negative, sometimes negative or negative zero
  task automatic put_count();
    int r;
    r = $urandom_range(99);
    if (r < 5) put_varint(1'b1, rand_mag() | 62'd1);
    else if (r < 10) put_varint(1'b1, '0);
    else put_varint(1'b0, rand_mag());
  endtask

  task automatic put_record(input logic big);
    logic [15:0] m;
    logic [61:0] mag;
    int r;
    r = $urandom_range(99);
    if (r < 3) m = 16'd0;
    else if (r < 6) m = 16'd1439;
    else if (r < 10) m = 16'($urandom_range(1440, 65535));
    else m = 16'($urandom_range(0, 1439));
    pay_q.insert(pay_q.size(), m[7:0]);
    pay_q.insert(pay_q.size(), m[15:8]);
    // price step: large climbs, pullbacks within the running price, rare dips
    r = $urandom_range(99);
    if (big) begin
      mag = {1'b1, 61'({$urandom, $urandom})};
      put_varint(1'b0, mag);
      gen_price = gen_price + $signed({2'b00, mag});
    end else if (gen_price > 0 && r < 40) begin
      mag = gen_price[61:0] >> $urandom_range(0, 6);
      put_varint(1'b1, mag);
      gen_price = gen_price - $signed({2'b00, mag});
    end else if (r < 44) begin
      put_varint(1'b1, rand_mag() | 62'd1);
    end else begin
      mag = rand_mag();
      put_varint(1'b0, mag);
      gen_price = gen_price + $signed({2'b00, mag});
    end
    put_count();
    put_count();
    put_varint(1'($urandom_range(1)), rand_mag());
    put_varint(1'($urandom_range(1)), rand_mag());
  endtask

  // one payload: mostly well formed records, some short, cut off, padded or noise
  task automatic run_payload();
    int kind;
    int nrec;
    logic big;
    trvp_pkg::in_item_t it;
    pay_q.delete();
    gen_price = '0;
    kind = $urandom_range(99);
    if (cfg_records == 0) nrec = $urandom_range(1, 3);
    else if (cfg_records > 8) nrec = $urandom_range(1, 4);
    else nrec = cfg_records;
    if (kind < 10) begin
      repeat ($urandom_range(1, 24)) pay_q.insert(pay_q.size(), 8'($urandom));
    end else begin
      big = ($urandom_range(7) == 0);
      if (kind < 20) nrec = nrec - 1;
      for (int i = 0; i < nrec; i++) put_record(big);
      if (kind >= 20 && kind < 35 && pay_q.size() > 1)
        pay_q = pay_q[0:$urandom_range(0, pay_q.size() - 1)];
      else if (kind >= 35 && kind < 50)
        repeat ($urandom_range(1, 5)) pay_q.insert(pay_q.size(), 8'($urandom));
    end
    if (pay_q.size() == 0) pay_q.insert(0, 8'($urandom));
    foreach (pay_q[i]) begin
      it.data_byte = pay_q[i];
      it.payload_end = (i == pay_q.size() - 1);
      feed(it, 1'b0, trvp_pkg::ErrNone);
    end
    if ($urandom_range(9) == 0) quiesce();
  endtask

  task automatic check_result(input trvp_pkg::out_item_t got);
    trvp_pkg::out_item_t want;
    codes_seen[got.error_code] = 1'b1;
    if (got.error_code == trvp_pkg::ErrNone) records_seen++;
    else errors_seen++;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected: record %0d code %0d",
                                got.record_number, got.error_code));
    end else begin
      want = pending_results.pop_front();
      if (got.record_number !== want.record_number)
        report_mismatch($sformatf("record_number %h want %h",
                                  got.record_number, want.record_number));
      if (got.absolute_number !== want.absolute_number)
        report_mismatch($sformatf("absolute_number %h want %h",
                                  got.absolute_number, want.absolute_number));
      if (got.minute_of_day !== want.minute_of_day)
        report_mismatch($sformatf("minute_of_day %h want %h",
                                  got.minute_of_day, want.minute_of_day));
      if (got.price_step !== want.price_step)
        report_mismatch($sformatf("price_step %h want %h", got.price_step, want.price_step));
      if (got.price_running !== want.price_running)
        report_mismatch($sformatf("price_running %h want %h",
                                  got.price_running, want.price_running));
      if (got.volume !== want.volume)
        report_mismatch($sformatf("volume %h want %h", got.volume, want.volume));
      if (got.orders !== want.orders)
        report_mismatch($sformatf("orders %h want %h", got.orders, want.orders));
      if (got.status_word !== want.status_word)
        report_mismatch($sformatf("status_word %h want %h",
                                  got.status_word, want.status_word));
      if (got.tail_word !== want.tail_word)
        report_mismatch($sformatf("tail_word %h want %h", got.tail_word, want.tail_word));
      if (got.error_code !== want.error_code)
        report_mismatch($sformatf("error_code %0d want %0d",
                                  got.error_code, want.error_code));
      if (got.last_of_run !== want.last_of_run)
        report_mismatch($sformatf("last_of_run %b want %b",
                                  got.last_of_run, want.last_of_run));
    end
  endtask

  // output side: random stall, result checking and the no-progress watchdog
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_pct);
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (out_valid_o && !out_stall_i) check_result(out_data_o);
      if (quiet_cycles >= QuietLimit) begin
        $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                 quiet_cycles, pending_results.size());
        $display("** trade_record_varint_parser: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    trvp_pkg::in_item_t it;
    cfg_records = '0;
    cfg_start = '0;
    lo_byte = '0;
    minute_q = '0;
    foreach (fld[i]) fld[i] = '0;
    clear_record_state();
    set_idle(0);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed table
    write_reg(trvp_pkg::RegRecordCount, 16'd2);
    write_reg(trvp_pkg::RegStartIndex, 16'hFFFF);
    for (int i = 0; i < DirLen; i++) begin
      for (int k = 0; k < DirRows[i].reps; k++) begin
        it.data_byte = DirRows[i].data;
        it.payload_end = DirRows[i].fin;
        feed(it, DirRows[i].typed, DirRows[i].err);
      end
    end

    // random phases, each under its own register setting
    for (int p = 0; p < PhaseCnt; p++) begin
      int target;
      int np;
      quiesce();
      set_idle(p < 4 ? 0 : (p < 7 ? 1 : 2));
      write_reg(trvp_pkg::RegRecordCount, PhaseRecords[p]);
      write_reg(trvp_pkg::RegStartIndex, PhaseStarts[p]);
      target = bytes_sent + BytesPerPhase;
      np = 0;
      while (bytes_sent < target && np < (PhaseRecords[p] == 0 ? 6 : 60)) begin
        run_payload();
        np++;
      end
    end

    quiesce();
    repeat (10) @(posedge clk_i);
    $display("sent %0d bytes (%0d decoded) under %0d register settings",
             bytes_sent, live_bytes, PhaseCnt + 1);
    $display("checked %0d records and %0d error results, codes seen %b",
             records_seen, errors_seen, codes_seen[8:0]);
    if (mismatches == 0) begin
      $display("** trade_record_varint_parser: PASSED **");
    end else begin
      $display("** trade_record_varint_parser: FAILED **");
    end
    $finish;
  end

endmodule

/* trade_record_varint_parser.f */
sv/trvp_pkg.sv
sv/trvp_result_fifo.sv
sv/trade_record_varint_parser.sv
test/tb.sv
